/* hdl/positional_list_engine_macros.svh */
// Assertion macros for the positional list engine checker.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, suspended while reset is high.
`define PLE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, suspended while reset is high.
`define PLE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define PLE_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/ple_pkg.sv */
// Types and constants shared by the positional list engine.
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

   localparam int ACTION_W = 2;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_READ   = 2'd2,
      ACT_WRITE  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Broadcast to every cell of the chain in the cycle an item is accepted
   typedef struct packed {
      logic                go;     // item accepted, position in range, and room left for an insert
      action_type          act;
      logic [POS_W-1:0]    pidx;   // zero-based slot, position minus one
      logic [DATA_W-1:0]   value;
   } cell_cmd_type;

endpackage
`default_nettype wire

/* hdl/ple_channels.sv */
// Valid/ready channel interfaces for list requests and responses.
`timescale 1ns / 1ps
`default_nettype none
interface ple_req_if
   import ple_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic [ACTION_W-1:0]         action;
   logic [POS_W-1:0]            position;
   logic signed [DATA_W-1:0]    new_value;

   modport source (output valid, action, position, new_value, input ready);
   modport sink   (input valid, action, position, new_value, output ready);
endinterface

interface ple_rsp_if
   import ple_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic [STATUS_W-1:0]         status;
   logic signed [DATA_W-1:0]    element;
   logic [LEN_W-1:0]            length;

   modport source (output valid, status, element, length, input ready);
   modport sink   (input valid, status, element, length, output ready);
endinterface
`default_nettype wire

/* hdl/ple_cell.sv */
// One slot of the list chain: holds an element and shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none
module ple_cell
   import ple_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  wire logic                clock,
   input  wire cell_cmd_type        cmd,
   input  wire logic [DATA_W-1:0]   left_data,
   input  wire logic [DATA_W-1:0]   right_data,
   output logic [DATA_W-1:0]        data_out,
   output logic [DATA_W-1:0]        read_out
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              at_slot;
   logic              past_slot;

   // Where this slot sits relative to the addressed one
   assign at_slot   = (32'(INDEX) == 32'(cmd.pidx));
   assign past_slot = (32'(INDEX) >  32'(cmd.pidx));

   // Insert opens a gap, delete closes it, overwrite loads in place
   always_comb begin
      data_in = data_ff;
      if (cmd.go) begin
         case (cmd.act)
            ACT_INSERT: begin
               if (at_slot) data_in = cmd.value;
               else if (past_slot) data_in = left_data;
            end
            ACT_DELETE: begin
               if (at_slot || past_slot) data_in = right_data;
            end
            ACT_WRITE: begin
               if (at_slot) data_in = cmd.value;
            end
            default: data_in = data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   // Contributes to the read OR-tree only when addressed
   assign read_out = at_slot ? data_ff : '0;

endmodule
`default_nettype wire

/* hdl/positional_list_engine.sv */
// Top level of the positional list engine: a chain of element cells.
//
// Usage: items arrive on req_chan (action, position, new_value) and results
// leave on rsp_chan (status, element, length), both valid/ready channels; an
// item moves when valid and ready are high at a rising clock edge.
// Each slot of the list is one cell; an insert or delete moves every later
// cell by one place in the same cycle.
// The result is registered and shown in the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver takes results, set by
// the update of the cell chain and the output register.
// Stall: while a result waits untaken, req_chan.ready is low and the list
// holds; ready returns in the cycle the result is taken.
// Reset (synchronous, active high) empties the list and drops any pending
// result; cell contents are not cleared, slots beyond the count are never
// read. Length is reported modulo 32.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_engine
   import ple_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ple_req_if.sink    req_chan,
   ple_rsp_if.source  rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   status_type          status_ff;
   status_type          status_in;
   logic [DATA_W-1:0]   element_ff;
   logic [DATA_W-1:0]   element_in;
   logic [LEN_W-1:0]    length_ff;
   logic [LEN_W-1:0]    length_in;

   logic                accept;
   action_type          act;
   logic [CMP_W-1:0]    pos_c;
   logic [CMP_W-1:0]    cnt_c;
   logic                pos_nonzero;
   logic                ins_pos_ok;
   logic                acc_pos_ok;
   logic                is_full;
   cell_cmd_type        cmd;
   logic [DATA_W-1:0]   cell_data [DEPTH];
   logic [DATA_W-1:0]   cell_read [DEPTH];
   logic [DATA_W-1:0]   read_any;

   // Handshake: take a new item whenever the output register frees up
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign act            = action_type'(req_chan.action);

   // Position checks against the current count
   assign pos_c       = CMP_W'(req_chan.position);
   assign cnt_c       = CMP_W'(count_ff);
   assign pos_nonzero = (req_chan.position != '0);
   assign ins_pos_ok  = pos_nonzero && (pos_c <= cnt_c + CMP_W'(1));
   assign acc_pos_ok  = pos_nonzero && (pos_c <= cnt_c);
   assign is_full     = (cnt_c >= CMP_W'(DEPTH));

   // Command broadcast to the chain
   always_comb begin
      cmd.act   = act;
      cmd.pidx  = req_chan.position - POS_W'(1);
      cmd.value = req_chan.new_value;
      if (act == ACT_INSERT) cmd.go = accept && ins_pos_ok && !is_full;
      else                   cmd.go = accept && acc_pos_ok;
   end

   // Cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_d;
      logic [DATA_W-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = cmd.value;
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end
      ple_cell #(.INDEX(i)) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_d),
         .right_data (right_d),
         .data_out   (cell_data[i]),
         .read_out   (cell_read[i])
      );
   end

   // Addressed element: at most one cell drives a non-zero value
   always_comb begin
      read_any = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_any = read_any | cell_read[i];
      end
   end

   // Result and next count
   always_comb begin
      count_in     = count_ff;
      status_in    = status_ff;
      element_in   = element_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         element_in   = '0;
         status_in    = ST_OK;
         case (act)
            ACT_INSERT: begin
               if (!ins_pos_ok)  status_in = ST_RANGE;
               else if (is_full) status_in = ST_FULL;
               else              count_in  = count_ff + CNT_W'(1);
            end
            ACT_DELETE: begin
               if (!acc_pos_ok) status_in = ST_RANGE;
               else begin
                  element_in = read_any;
                  count_in   = count_ff - CNT_W'(1);
               end
            end
            ACT_READ: begin
               if (!acc_pos_ok) status_in = ST_RANGE;
               else             element_in = read_any;
            end
            ACT_WRITE: begin
               if (!acc_pos_ok) status_in = ST_RANGE;
            end
            default: status_in = ST_RANGE;
         endcase
      end
      length_in = accept ? LEN_W'(count_in) : length_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff  <= status_in;
      element_ff <= element_in;
      length_ff  <= length_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.status  = status_ff;
   assign rsp_chan.element = element_ff;
   assign rsp_chan.length  = length_ff;

endmodule
`default_nettype wire

/* hdl/ple_checker.sv */
// Port-level checks for the positional list engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_macros.svh"
module ple_checker
   import ple_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [STATUS_W-1:0]  rsp_status,
   input wire logic [DATA_W-1:0]    rsp_element,
   input wire logic [LEN_W-1:0]     rsp_length
);

   // Nothing pending straight after reset
   `PLE_ASSERT_ALWAYS_NEXT(a_rst_empty, clock, reset, !rsp_valid, "result valid after reset")

   // An accepted item yields a result in the next cycle
   `PLE_ASSERT_NEXT(a_one_cycle, clock, reset, req_valid && req_ready, rsp_valid, "result missing after accepted item")

   // A waiting result blocks new items
   `PLE_ASSERT_SAME(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready, "item taken while result stalled")

   // Errors carry no element
   `PLE_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_element == '0, "error result with element")

   // A full answer reports the full length
   `PLE_ASSERT_SAME(a_full_len, clock, reset, rsp_valid && (rsp_status == ST_FULL), rsp_length == LEN_W'(DEPTH), "full status with wrong length")

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_status  (rsp_chan.status),
   .rsp_element (rsp_chan.element),
   .rsp_length  (rsp_chan.length)
);
`default_nettype wire
